>>> hdl/dsn_pkg.sv
package dsn_pkg;

   localparam int WIDTH_REG_BITS  = 11;
   localparam int HEIGHT_REG_BITS = 13;
   localparam int CSR_DATA_BITS   = 13;
   localparam int CSR_INDEX_BITS  = 1;
   localparam int ROW_BITS        = 13;
   localparam int MAX_HEIGHT      = 4096;
   localparam int MIN_SIZE        = 3;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_HEIGHT = 1'd1;

   localparam logic [WIDTH_REG_BITS-1:0]  WIDTH_RESET  = 11'd640;
   localparam logic [HEIGHT_REG_BITS-1:0] HEIGHT_RESET = 13'd480;

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_READ  = 9'b000000010,
      ST_RIGHT = 9'b000000100,
      ST_MUL   = 9'b000001000,
      ST_SUM   = 9'b000010000,
      ST_NORM  = 9'b000100000,
      ST_OUT1  = 9'b001000000,
      ST_OUT2  = 9'b010000000,
      ST_START = 9'b100000000
   } dsn_state_type;

endpackage

>>> hdl/dsn_ram.sv
module dsn_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

>>> hdl/dsn_normalizer.sv
module dsn_normalizer #(
   parameter int S_BITS    = 34,
   parameter int M_BITS    = 34,
   parameter int FRAC_BITS = 14
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [S_BITS-1:0]    sum_sq,
   input  logic [M_BITS-1:0]    mag_sq,
   output logic                 done,
   output logic [FRAC_BITS:0]   quotient
);

   localparam int QB   = FRAC_BITS + 1;
   localparam int ACCW = 2 * QB + 3 + S_BITS;
   localparam int BB   = $clog2(QB);

   logic [ACCW-1:0] p_ff, p_in, x_ff, x_in, lim_ff, lim_in, sx_ff, sx_in;
   logic [ACCW-1:0] p_try, x_try, t_try;
   logic [QB-1:0]   quo_ff, quo_in;
   logic [BB-1:0]   bit_ff, bit_in;
   logic            busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      p_try = p_ff + (x_ff << (bit_ff + 2)) + (sx_ff << (2 * bit_ff + 2));
      x_try = x_ff + (sx_ff << (bit_ff + 1));
      t_try = p_try - (x_try << 1) + sx_ff;
   end

   always_comb begin
      p_in    = p_ff;
      x_in    = x_ff;
      lim_in  = lim_ff;
      sx_in   = sx_ff;
      quo_in  = quo_ff;
      bit_in  = bit_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         p_in    = '0;
         x_in    = '0;
         quo_in  = '0;
         sx_in   = ACCW'(sum_sq);
         lim_in  = ACCW'(mag_sq) << (2 * FRAC_BITS + 2);
         bit_in  = BB'(QB - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (t_try <= lim_ff) begin
            p_in           = p_try;
            x_in           = x_try;
            quo_in[bit_ff] = 1'b1;
         end
         if (bit_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            bit_in = bit_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      p_ff   <= p_in;
      x_ff   <= x_in;
      lim_ff <= lim_in;
      sx_ff  <= sx_in;
      quo_ff <= quo_in;
      bit_ff <= bit_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> hdl/depth_surface_normal_stream_top.sv
// Surface normals of a depth frame by central differences. Depth pixels enter in
// raster order; the result for a pixel comes out while the pixel below it is taken,
// so results lag one row, and each pixel of the last row also gives its own border
// result. Two line stores of MAX_WIDTH entries, each a single-port-read RAM, hold
// the two previous rows. One request is handled at a time. A first-row pixel is only
// stored and a border pixel gives a border result; an interior pixel has its gradients
// squared and summed, then the shared bit-serial unit forms the three normalized
// components one after another, one quotient bit per cycle. A last-row pixel also
// gives its own border result. Each result also waits while rsp_stall is high.
module depth_surface_normal_stream_top #(
   parameter int MAX_WIDTH  = 1024,
   parameter int DEPTH_BITS = 16,
   parameter int FRAC_BITS  = 14
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [DEPTH_BITS-1:0]                 req_depth,
   input  logic                                  req_frame_start,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [FRAC_BITS+1:0]           rsp_normal_first,
   output logic signed [FRAC_BITS+1:0]           rsp_normal_second,
   output logic [FRAC_BITS:0]                    rsp_normal_third,
   output logic                                  rsp_is_border,
   output logic                                  rsp_last_of_frame,
   input  logic                                  csr_write,
   input  logic [dsn_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [dsn_pkg::CSR_DATA_BITS-1:0]     csr_data
);

   localparam int CB = $clog2(MAX_WIDTH + 1);
   localparam int AB = $clog2(MAX_WIDTH);
   localparam int RB = dsn_pkg::ROW_BITS;
   localparam int GB = DEPTH_BITS + 1;
   localparam int MB = 2 * GB;
   localparam int SB = 2 * DEPTH_BITS + 2;
   localparam int OB = FRAC_BITS + 2;

   dsn_pkg::dsn_state_type state_ff, state_in;

   logic [dsn_pkg::WIDTH_REG_BITS-1:0]  width_ff;
   logic [dsn_pkg::HEIGHT_REG_BITS-1:0] height_ff;
   logic [CB-1:0] wc, col_ff, col_in, col_a, col_n, c_ff, c_in;
   logic [RB-1:0] hc, row_ff, row_in, row_a, row_n, r_ff, r_in;
   logic [DEPTH_BITS-1:0] d_ff, d_in, above_ff, above_in, mid_ff, mid_in, left_ff, left_in;
   logic signed [GB-1:0] gx_ff, gx_in, gy_ff, gy_in;
   logic [MB-1:0] gx2_ff, gx2_in, gy2_ff, gy2_in, mag_sel;
   logic [SB-1:0] s_ff, s_in;
   logic [1:0] comp_ff, comp_in;
   logic lastrow_ff, lastrow_in;
   logic signed [OB-1:0] first_ff, first_in, second_ff, second_in;
   logic [FRAC_BITS:0] third_ff, third_in;
   logic border_ff, border_in, last_ff, last_in;
   logic [AB-1:0] old_rd_addr, new_rd_addr;
   logic [DEPTH_BITS-1:0] old_rd_data, new_rd_data;
   logic store_wr;
   logic norm_start, norm_done;
   logic [FRAC_BITS:0] norm_q;
   logic [1:0] next_comp;
   logic signed [OB-1:0] q_signed;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= dsn_pkg::WIDTH_RESET;
         height_ff <= dsn_pkg::HEIGHT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            dsn_pkg::CSR_IMAGE_WIDTH: begin
               width_ff <= csr_data[dsn_pkg::WIDTH_REG_BITS-1:0];
            end
            dsn_pkg::CSR_IMAGE_HEIGHT: begin
               height_ff <= csr_data[dsn_pkg::HEIGHT_REG_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (32'(width_ff) < dsn_pkg::MIN_SIZE) begin
         wc = CB'(dsn_pkg::MIN_SIZE);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         wc = CB'(MAX_WIDTH);
      end else begin
         wc = CB'(width_ff);
      end
      if (32'(height_ff) < dsn_pkg::MIN_SIZE) begin
         hc = RB'(dsn_pkg::MIN_SIZE);
      end else if (32'(height_ff) > dsn_pkg::MAX_HEIGHT) begin
         hc = RB'(dsn_pkg::MAX_HEIGHT);
      end else begin
         hc = RB'(height_ff);
      end
   end

   always_comb begin
      col_a = req_frame_start ? '0 : col_ff;
      row_a = req_frame_start ? '0 : row_ff;
      if (col_a >= wc) begin
         col_a = '0;
         row_a = row_a + 1'b1;
      end
      if (row_a >= hc) begin
         row_a = '0;
      end
      col_n = col_a + 1'b1;
      row_n = row_a;
      if (col_n >= wc) begin
         col_n = '0;
         row_n = row_a + 1'b1;
         if (row_n >= hc) begin
            row_n = '0;
         end
      end
   end

   assign old_rd_addr = col_a[AB-1:0];
   assign new_rd_addr = (state_ff == dsn_pkg::ST_READ) ? AB'(c_ff + 1'b1) : col_a[AB-1:0];
   assign store_wr    = (state_ff == dsn_pkg::ST_RIGHT);

   dsn_ram #(.WIDTH(DEPTH_BITS), .DEPTH(MAX_WIDTH)) u_older_ram (
      .clock   (clock),
      .wr_en   (store_wr),
      .wr_addr (c_ff[AB-1:0]),
      .wr_data (mid_ff),
      .rd_addr (old_rd_addr),
      .rd_data (old_rd_data)
   );

   dsn_ram #(.WIDTH(DEPTH_BITS), .DEPTH(MAX_WIDTH)) u_newer_ram (
      .clock   (clock),
      .wr_en   (store_wr),
      .wr_addr (c_ff[AB-1:0]),
      .wr_data (d_ff),
      .rd_addr (new_rd_addr),
      .rd_data (new_rd_data)
   );

   always_comb begin
      case (next_comp)
         2'd0:    mag_sel = gy2_ff;
         2'd1:    mag_sel = gx2_ff;
         default: mag_sel = MB'(4);
      endcase
   end

   dsn_normalizer #(.S_BITS(SB), .M_BITS(MB), .FRAC_BITS(FRAC_BITS)) u_normalizer (
      .clock    (clock),
      .reset    (reset),
      .start    (norm_start),
      .sum_sq   (s_ff),
      .mag_sq   (mag_sel),
      .done     (norm_done),
      .quotient (norm_q)
   );

   assign req_stall = (state_ff != dsn_pkg::ST_IDLE);
   assign rsp_valid = (state_ff == dsn_pkg::ST_OUT1) || (state_ff == dsn_pkg::ST_OUT2);

   always_comb begin
      state_in   = state_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      c_in       = c_ff;
      r_in       = r_ff;
      d_in       = d_ff;
      above_in   = above_ff;
      mid_in     = mid_ff;
      left_in    = left_ff;
      gx_in      = gx_ff;
      gy_in      = gy_ff;
      gx2_in     = gx2_ff;
      gy2_in     = gy2_ff;
      s_in       = s_ff;
      comp_in    = comp_ff;
      lastrow_in = lastrow_ff;
      first_in   = first_ff;
      second_in  = second_ff;
      third_in   = third_ff;
      border_in  = border_ff;
      last_in    = last_ff;
      norm_start = 1'b0;
      next_comp  = comp_ff;
      q_signed   = OB'(norm_q);
      case (state_ff)
         dsn_pkg::ST_IDLE: begin
            if (req_valid) begin
               c_in     = col_a;
               r_in     = row_a;
               d_in     = req_depth;
               col_in   = col_n;
               row_in   = row_n;
               state_in = dsn_pkg::ST_READ;
            end
         end
         dsn_pkg::ST_READ: begin
            above_in = old_rd_data;
            mid_in   = new_rd_data;
            state_in = dsn_pkg::ST_RIGHT;
         end
         dsn_pkg::ST_RIGHT: begin
            gx_in      = $signed({1'b0, new_rd_data}) - $signed({1'b0, left_ff});
            gy_in      = $signed({1'b0, d_ff}) - $signed({1'b0, above_ff});
            left_in    = mid_ff;
            lastrow_in = (r_ff == hc - 1'b1);
            first_in   = '0;
            second_in  = '0;
            third_in   = '0;
            border_in  = 1'b1;
            last_in    = 1'b0;
            if (r_ff == '0) begin
               if (r_ff == hc - 1'b1) begin
                  last_in  = (c_ff == wc - 1'b1);
                  state_in = dsn_pkg::ST_OUT2;
               end else begin
                  state_in = dsn_pkg::ST_IDLE;
               end
            end else if (r_ff == RB'(1) || c_ff == '0 || c_ff == wc - 1'b1) begin
               state_in = dsn_pkg::ST_OUT1;
            end else begin
               border_in = 1'b0;
               state_in  = dsn_pkg::ST_MUL;
            end
         end
         dsn_pkg::ST_MUL: begin
            gx2_in   = MB'(gx_ff * gx_ff);
            gy2_in   = MB'(gy_ff * gy_ff);
            state_in = dsn_pkg::ST_SUM;
         end
         dsn_pkg::ST_SUM: begin
            s_in     = SB'(gx2_ff) + SB'(gy2_ff) + SB'(4);
            comp_in  = 2'd0;
            state_in = dsn_pkg::ST_START;
         end
         dsn_pkg::ST_START: begin
            norm_start = 1'b1;
            next_comp  = comp_ff;
            state_in   = dsn_pkg::ST_NORM;
         end
         dsn_pkg::ST_NORM: begin
            if (norm_done) begin
               case (comp_ff)
                  2'd0: begin
                     first_in = (gy_ff > 0) ? -q_signed : q_signed;
                  end
                  2'd1: begin
                     second_in = (gx_ff > 0) ? -q_signed : q_signed;
                  end
                  default: begin
                     third_in = norm_q;
                  end
               endcase
               if (comp_ff == 2'd2) begin
                  state_in = dsn_pkg::ST_OUT1;
               end else begin
                  comp_in  = comp_ff + 1'b1;
                  state_in = dsn_pkg::ST_START;
               end
            end
         end
         dsn_pkg::ST_OUT1: begin
            if (!rsp_stall) begin
               if (lastrow_ff) begin
                  first_in  = '0;
                  second_in = '0;
                  third_in  = '0;
                  border_in = 1'b1;
                  last_in   = (c_ff == wc - 1'b1);
                  state_in  = dsn_pkg::ST_OUT2;
               end else begin
                  state_in = dsn_pkg::ST_IDLE;
               end
            end
         end
         dsn_pkg::ST_OUT2: begin
            if (!rsp_stall) begin
               state_in = dsn_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dsn_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dsn_pkg::ST_IDLE;
         col_ff   <= '0;
         row_ff   <= '0;
         left_ff  <= '0;
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         left_ff  <= left_in;
      end
      c_ff       <= c_in;
      r_ff       <= r_in;
      d_ff       <= d_in;
      above_ff   <= above_in;
      mid_ff     <= mid_in;
      gx_ff      <= gx_in;
      gy_ff      <= gy_in;
      gx2_ff     <= gx2_in;
      gy2_ff     <= gy2_in;
      s_ff       <= s_in;
      comp_ff    <= comp_in;
      lastrow_ff <= lastrow_in;
      first_ff   <= first_in;
      second_ff  <= second_in;
      third_ff   <= third_in;
      border_ff  <= border_in;
      last_ff    <= last_in;
   end

   assign rsp_normal_first  = first_ff;
   assign rsp_normal_second = second_ff;
   assign rsp_normal_third  = third_ff;
   assign rsp_is_border     = border_ff;
   assign rsp_last_of_frame = last_ff;

endmodule
